// File: rtl/pbp_pkg.sv
// Shared types and constants for the perceptron branch predictor.
package pbp_pkg;

    localparam int ADDR_W     = 10;
    localparam int THR_W      = 8;
    localparam int SUM_OUT_W  = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [THR_W-1:0] THR_RESET = 8'd37;

    localparam int SUM_OUT_MAX = 2047;
    localparam int SUM_OUT_MIN = -2048;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DONE
    } pbp_state_t;

    typedef struct packed {
        logic clear;
        logic load_item;
        logic finish;
    } pbp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } pbp_status_t;

endpackage

// File: rtl/pbp_ctrl.sv
// Sequencing state machine for the perceptron branch predictor.
module pbp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pbp_pkg::pbp_status_t status,
    output pbp_pkg::pbp_cmd_t    cmd
);

    pbp_pkg::pbp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbp_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.clear     = 1'b0;
        cmd.load_item = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            pbp_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clr_last) begin
                    state_next = pbp_pkg::ST_IDLE;
                end
            end
            pbp_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
                if (s_tvalid) begin
                    state_next = pbp_pkg::ST_READ;
                end
            end
            pbp_pkg::ST_READ: begin
                state_next = pbp_pkg::ST_SUM;
            end
            pbp_pkg::ST_SUM: begin
                state_next = pbp_pkg::ST_DONE;
            end
            pbp_pkg::ST_DONE: begin
                // Hold here until the result register can take the new result.
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = pbp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pbp_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/pbp_datapath.sv
// Weight memory, history, adder tree, training logic and result register.
module pbp_datapath #(
    parameter int HISTORY_LEN = 12,
    parameter int INDEX_BITS  = 10,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pbp_pkg::THR_W-1:0]          cfg_wr_data,
    input  logic                               in_func,
    input  logic [pbp_pkg::ADDR_W-1:0]         in_branch_addr,
    input  logic                               in_cond_branch,
    input  logic                               in_outcome_taken,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic                               out_predict_taken,
    output logic [pbp_pkg::SUM_OUT_W-1:0]      out_sum,
    output logic                               out_trained,
    input  pbp_pkg::pbp_cmd_t                  cmd,
    output pbp_pkg::pbp_status_t               status
);

    localparam int ROWS    = 1 << INDEX_BITS;
    localparam int ROW_LEN = HISTORY_LEN + 1;
    localparam int WB      = WEIGHT_BITS;
    localparam int ROW_W   = ROW_LEN * WB;
    localparam int GROUP   = 8;
    localparam int NGRP    = (ROW_LEN + GROUP - 1) / GROUP;
    localparam int PAD_LEN = NGRP * GROUP;
    localparam int SW      = WB + $clog2(ROW_LEN) + 1;
    localparam int MW      = (SW > pbp_pkg::THR_W) ? SW : pbp_pkg::THR_W;
    localparam int EW      = (SW > pbp_pkg::SUM_OUT_W) ? SW : pbp_pkg::SUM_OUT_W;

    localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
    localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
    localparam logic signed [EW-1:0] SAT_HI = EW'(pbp_pkg::SUM_OUT_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(pbp_pkg::SUM_OUT_MIN);

    logic [ROW_W-1:0]             weight_mem [ROWS];
    logic [ROW_W-1:0]             rd_row_reg;
    logic [INDEX_BITS-1:0]        clr_idx_reg;
    logic [INDEX_BITS-1:0]        idx_reg;
    logic                         func_reg;
    logic                         cond_reg;
    logic                         taken_reg;
    logic [HISTORY_LEN-1:0]       hist_reg;
    logic [pbp_pkg::THR_W-1:0]    thr_reg;
    logic signed [SW-1:0]         grp_reg [NGRP];
    logic signed [SW-1:0]         grp_next [NGRP];
    logic signed [SW-1:0]         sum_reg;
    logic signed [SW-1:0]         sum_next;
    logic                         m_tvalid_reg;
    logic                         predict_reg;
    logic [pbp_pkg::SUM_OUT_W-1:0] sum_out_reg;
    logic                         trained_reg;

    logic [PAD_LEN*WB-1:0]        row_pad;
    logic [PAD_LEN-1:0]           x_pad;
    logic [ROW_LEN-1:0]           x_vec;
    logic                         pred;
    logic [SW-1:0]                mag;
    logic                         do_train;
    logic                         do_update;
    logic [ROW_W-1:0]             new_row;
    logic signed [EW-1:0]         sum_ext;
    logic [pbp_pkg::SUM_OUT_W-1:0] sum_sat;
    logic                         mem_we;
    logic [INDEX_BITS-1:0]        wr_addr;
    logic [ROW_W-1:0]             wr_data;

    // Sign selector per weight: the bias always counts positive.
    assign x_vec   = {hist_reg, 1'b1};
    assign x_pad   = PAD_LEN'(x_vec);
    assign row_pad = (PAD_LEN*WB)'(rd_row_reg);

    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [WB-1:0] w;
        for (int g = 0; g < NGRP; g++) begin
            acc = '0;
            for (int k = 0; k < GROUP; k++) begin
                w = row_pad[(g*GROUP+k)*WB +: WB];
                if (x_pad[g*GROUP+k]) begin
                    acc = acc + SW'(w);
                end else begin
                    acc = acc - SW'(w);
                end
            end
            grp_next[g] = acc;
        end
    end

    always_comb begin
        sum_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            sum_next = sum_next + grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_reg[g] <= grp_next[g];
        end
        sum_reg <= sum_next;
    end

    assign pred      = cond_reg ? ~sum_reg[SW-1] : 1'b1;
    assign mag       = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign do_update = (func_reg == pbp_pkg::FUNC_UPDATE) && cond_reg;
    assign do_train  = do_update &&
                       ((pred != taken_reg) || (MW'(mag) <= MW'(thr_reg)));

    always_comb begin
        logic signed [WB-1:0] w;
        for (int e = 0; e < ROW_LEN; e++) begin
            w = rd_row_reg[e*WB +: WB];
            if (x_vec[e] == taken_reg) begin
                new_row[e*WB +: WB] = (w == W_MAX) ? W_MAX : w + WB'(1);
            end else begin
                new_row[e*WB +: WB] = (w == W_MIN) ? W_MIN : w - WB'(1);
            end
        end
    end

    assign sum_ext = EW'(sum_reg);
    always_comb begin
        if (sum_ext > SAT_HI) begin
            sum_sat = pbp_pkg::SUM_OUT_W'(SAT_HI);
        end else if (sum_ext < SAT_LO) begin
            sum_sat = pbp_pkg::SUM_OUT_W'(SAT_LO);
        end else begin
            sum_sat = pbp_pkg::SUM_OUT_W'(sum_ext);
        end
    end

    assign mem_we  = cmd.clear | (cmd.finish & do_train);
    assign wr_addr = cmd.clear ? clr_idx_reg : idx_reg;
    assign wr_data = cmd.clear ? '0 : new_row;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            weight_mem[wr_addr] <= wr_data;
        end
        if (cmd.load_item) begin
            rd_row_reg <= weight_mem[INDEX_BITS'(in_branch_addr)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            idx_reg   <= INDEX_BITS'(in_branch_addr);
            func_reg  <= in_func;
            cond_reg  <= in_cond_branch;
            taken_reg <= in_outcome_taken;
        end
        if (cmd.finish) begin
            predict_reg <= pred;
            sum_out_reg <= sum_sat;
            trained_reg <= do_train;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            hist_reg     <= '0;
            thr_reg      <= pbp_pkg::THR_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.finish && do_update) begin
                hist_reg <= HISTORY_LEN'({hist_reg, taken_reg});
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last   = (clr_idx_reg == {INDEX_BITS{1'b1}});
    assign status.out_free   = ~m_tvalid_reg | m_tready;
    assign m_tvalid          = m_tvalid_reg;
    assign out_predict_taken = predict_reg;
    assign out_sum           = sum_out_reg;
    assign out_trained       = trained_reg;

endmodule

// File: rtl/perceptron_branch_predictor_unit.sv
// Top level of the perceptron branch predictor with global history.
// A result is registered after a row read, two adder-tree stages, then decision
// and write-back. A new transaction is accepted only after the previous result is
// registered; a stalled result channel holds off the next one.
// Reset: synchronous active-low; afterwards a clearing pass zeroes all
// 2**INDEX_BITS rows (1024 by default) of the weight memory, one row per cycle.
module perceptron_branch_predictor_unit #(
    parameter int HISTORY_LEN = 12,
    parameter int INDEX_BITS  = 10,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Training threshold register write.
    input  logic                              cfg_wr_en,
    input  logic [pbp_pkg::THR_W-1:0]         cfg_wr_data,
    // Input channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata from bit 0: branch_addr[9:0], conditional flag, outcome_taken, zero pad.
    input  logic [pbp_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: func (0 predict only, 1 update).
    input  logic                              s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata from bit 0: predict_taken, output_sum[11:0], trained, zero pad.
    output logic [pbp_pkg::M_TDATA_W-1:0]     m_tdata
);

    pbp_pkg::pbp_cmd_t    cmd;
    pbp_pkg::pbp_status_t status;

    logic                          out_predict_taken;
    logic [pbp_pkg::SUM_OUT_W-1:0] out_sum;
    logic                          out_trained;

    // The controller only sequences; every weight, history bit and result
    // lives in the datapath.
    pbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbp_datapath #(
        .HISTORY_LEN (HISTORY_LEN),
        .INDEX_BITS  (INDEX_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_func           (s_tuser),
        .in_branch_addr    (s_tdata[pbp_pkg::ADDR_W-1:0]),
        .in_cond_branch    (s_tdata[pbp_pkg::ADDR_W]),
        .in_outcome_taken  (s_tdata[pbp_pkg::ADDR_W+1]),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_predict_taken (out_predict_taken),
        .out_sum           (out_sum),
        .out_trained       (out_trained),
        .cmd               (cmd),
        .status            (status)
    );

    // Pack the result transaction; unused upper bits are zero.
    assign m_tdata = pbp_pkg::M_TDATA_W'({out_trained, out_sum, out_predict_taken});

endmodule
